// ===== rtl/polygon_sharp_corner_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Polygon sharp corner filter assertion macros
// Shared property forms for the checker of the filter core.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SHARP_CORNER_FILTER_CORE_ASSERT_SVH
`define POLYGON_SHARP_CORNER_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PSCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pscf check failed");

// Next-cycle implication, disabled in reset.
`define PSCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pscf check failed");

`endif

// ===== rtl/pscf_pkg.sv =====
// ----------------------------------------------------------------------------
// Polygon sharp corner filter package
// Types and fixed constants shared by the filter core and its corner judge.
// ----------------------------------------------------------------------------
package pscf_pkg;

  localparam int IDX_W = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef enum logic [2:0] {
    T_IDLE,
    T_PLAN,
    T_START,
    T_WAIT,
    T_LOAD,
    T_COMMIT
  } top_state_t;

  // Which verdict of the current vertex is being produced
  typedef enum logic [1:0] {
    V_MID,
    V_LAST,
    V_FIRST,
    V_SINGLE
  } verdict_t;

  typedef enum logic [1:0] {
    J_IDLE,
    J_MUL,
    J_ACC
  } jstate_t;

  typedef enum logic [3:0] {
    JS_DOT_X,
    JS_DOT_Y,
    JS_CRS_A,
    JS_CRS_B,
    JS_DSQ_HH,
    JS_DSQ_HL,
    JS_DSQ_LL,
    JS_CSQ_HH,
    JS_CSQ_HL,
    JS_CSQ_LL,
    JS_CMP
  } jstep_t;

  typedef struct packed {
    logic done;
    logic keep;
  } judge_stat_t;

endpackage

// ===== rtl/polygon_sharp_corner_filter_core.sv =====
// ----------------------------------------------------------------------------
// Polygon sharp corner filter core
// Streams the vertices of closed polygons and gives a keep/drop verdict for
// each vertex; sharp corners (turn cosine at or below -1/2) are dropped.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one vertex per transfer, in_closes_polygon marks the last
//   vertex. in_stall is high while a vertex is in work.
//   Output channel: one verdict per transfer with index, coordinates, keep and
//   end_of_polygon (set on vertex 0's verdict, which comes last).
//   The verdict for vertex k leaves while vertex k+1 is handled; the closing
//   vertex gives the verdicts for the vertex before it, itself and vertex 0.
//   Each verdict's corner test uses the one shared multiplier, which
//   runs ten multiply/accumulate steps (dot, cross, and their squares in
//   half-width pieces); the test ends after the dot steps when the corner
//   is right or obtuse or an edge has zero length.
//   Stalling the output holds the verdict register; the core waits in turn
//   until its next verdict can be loaded.
//   Reset clears the polygon state; the next vertex starts a new polygon.
// ----------------------------------------------------------------------------
module polygon_sharp_corner_filter_core import pscf_pkg::*; #(
  parameter int COORD_BITS   = 16,
  parameter int MAX_VERTICES = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic                         in_closes_polygon,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [IDX_W-1:0]             out_vertex_index,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_keep,
  output logic                         out_end_of_polygon
);

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SAT_W = CNT_W + IDX_W;

  top_state_t st_r, st_nxt;
  verdict_t   vk_r, vk_nxt;

  logic signed [CW-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic                 close_r, close_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [CW-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [CW-1:0] second_x_r, second_x_nxt, second_y_r, second_y_nxt;
  logic signed [CW-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic                 vkeep_r, vkeep_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic signed [CW-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                 out_keep_r, out_keep_nxt, out_end_r, out_end_nxt;

  logic                 jstart;
  judge_stat_t          jstat;
  logic signed [CW-1:0] jax, jay, jbx, jby, jcx, jcy, sx, sy;

  logic [CNT_W-1:0]     idx_raw;
  logic [SAT_W-1:0]     idx_wide;
  logic [IDX_W-1:0]     idx_sat;
  logic signed [CW-1:0] vx, vy;
  logic                 vend;

  // Vertex 0's far neighbor: vertex 1, which is the closing one itself
  // for a two-vertex polygon
  assign sx = (cnt_r == CNT_W'(1)) ? nx_r : second_x_r;
  assign sy = (cnt_r == CNT_W'(1)) ? ny_r : second_y_r;

  always_comb begin
    unique case (vk_r)
      V_MID: begin
        jax = prev_x_r; jay = prev_y_r;
        jbx = cur_x_r;  jby = cur_y_r;
        jcx = nx_r;     jcy = ny_r;
      end
      V_LAST: begin
        jax = cur_x_r;   jay = cur_y_r;
        jbx = nx_r;      jby = ny_r;
        jcx = first_x_r; jcy = first_y_r;
      end
      V_FIRST: begin
        jax = nx_r;      jay = ny_r;
        jbx = first_x_r; jby = first_y_r;
        jcx = sx;        jcy = sy;
      end
      default: begin
        jax = nx_r; jay = ny_r;
        jbx = nx_r; jby = ny_r;
        jcx = nx_r; jcy = ny_r;
      end
    endcase
  end

  // Verdict payload for the current verdict kind
  always_comb begin
    unique case (vk_r)
      V_MID: begin
        idx_raw = cnt_r - CNT_W'(1);
        vx      = cur_x_r;
        vy      = cur_y_r;
        vend    = 1'b0;
      end
      V_LAST: begin
        idx_raw = cnt_r;
        vx      = nx_r;
        vy      = ny_r;
        vend    = 1'b0;
      end
      V_FIRST: begin
        idx_raw = '0;
        vx      = first_x_r;
        vy      = first_y_r;
        vend    = 1'b1;
      end
      default: begin
        idx_raw = '0;
        vx      = nx_r;
        vy      = ny_r;
        vend    = 1'b1;
      end
    endcase
  end

  assign idx_wide = SAT_W'(idx_raw);
  assign idx_sat  = (idx_wide > SAT_W'(IDX_MAX)) ? IDX_MAX : idx_wide[IDX_W-1:0];

  pscf_judge #(
    .CW (CW)
  ) u_judge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (jstart),
    .ax    (jax),
    .ay    (jay),
    .bx    (jbx),
    .by    (jby),
    .cx    (jcx),
    .cy    (jcy),
    .stat  (jstat)
  );

  always_comb begin
    st_nxt       = st_r;
    vk_nxt       = vk_r;
    nx_nxt       = nx_r;
    ny_nxt       = ny_r;
    close_nxt    = close_r;
    cnt_nxt      = cnt_r;
    first_x_nxt  = first_x_r;
    first_y_nxt  = first_y_r;
    second_x_nxt = second_x_r;
    second_y_nxt = second_y_r;
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    vkeep_nxt    = vkeep_r;
    out_idx_nxt  = out_idx_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_keep_nxt = out_keep_r;
    out_end_nxt  = out_end_r;
    // Drop the verdict once it is taken
    out_valid_nxt = out_valid_r && out_stall;
    jstart        = 1'b0;
    unique case (st_r)
      T_IDLE: begin
        if (in_valid) begin
          nx_nxt    = in_vertex_x;
          ny_nxt    = in_vertex_y;
          close_nxt = in_closes_polygon;
          st_nxt    = T_PLAN;
        end
      end
      T_PLAN: begin
        priority if (cnt_r >= CNT_W'(2)) begin
          vk_nxt = V_MID;
          st_nxt = T_START;
        end else if (close_r && (cnt_r == '0)) begin
          vk_nxt    = V_SINGLE;
          vkeep_nxt = 1'b0;
          st_nxt    = T_LOAD;
        end else if (close_r) begin
          vk_nxt = V_LAST;
          st_nxt = T_START;
        end else begin
          st_nxt = T_COMMIT;
        end
      end
      T_START: begin
        jstart = 1'b1;
        st_nxt = T_WAIT;
      end
      T_WAIT: begin
        if (jstat.done) begin
          vkeep_nxt = jstat.keep;
          st_nxt    = T_LOAD;
        end
      end
      T_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_sat;
          out_x_nxt     = vx;
          out_y_nxt     = vy;
          out_keep_nxt  = vkeep_r;
          out_end_nxt   = vend;
          unique case (vk_r)
            V_MID: begin
              if (close_r) begin
                vk_nxt = V_LAST;
                st_nxt = T_START;
              end else begin
                st_nxt = T_COMMIT;
              end
            end
            V_LAST: begin
              vk_nxt = V_FIRST;
              st_nxt = T_START;
            end
            default: st_nxt = T_COMMIT;
          endcase
        end
      end
      T_COMMIT: begin
        if (cnt_r == '0) begin
          first_x_nxt = nx_r;
          first_y_nxt = ny_r;
        end
        if (cnt_r == CNT_W'(1)) begin
          second_x_nxt = nx_r;
          second_y_nxt = ny_r;
        end
        prev_x_nxt = cur_x_r;
        prev_y_nxt = cur_y_r;
        cur_x_nxt  = nx_r;
        cur_y_nxt  = ny_r;
        if (close_r) begin
          cnt_nxt = '0;
        end else if (cnt_r < CNT_W'(MAX_VERTICES)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        st_nxt = T_IDLE;
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      vk_r        <= V_MID;
      cnt_r       <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      second_x_r  <= '0;
      second_y_r  <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      vk_r        <= vk_nxt;
      cnt_r       <= cnt_nxt;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      second_x_r  <= second_x_nxt;
      second_y_r  <= second_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    close_r    <= close_nxt;
    vkeep_r    <= vkeep_nxt;
    out_idx_r  <= out_idx_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_keep_r <= out_keep_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign in_stall           = (st_r != T_IDLE);
  assign out_valid          = out_valid_r;
  assign out_vertex_index   = out_idx_r;
  assign out_x              = out_x_r;
  assign out_y              = out_y_r;
  assign out_keep           = out_keep_r;
  assign out_end_of_polygon = out_end_r;

endmodule

// ===== rtl/pscf_judge.sv =====
// ----------------------------------------------------------------------------
// Corner judge
// Decides whether the corner at B of the path A-B-C is blunt enough to keep,
// using one shared multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
module pscf_judge import pscf_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  output judge_stat_t          stat
);

  localparam int DIFF_W = CW + 1;
  localparam int MUL_W  = CW + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DOT_W  = 2 * CW + 2;
  localparam int SQ_W   = 4 * CW + 2;
  localparam int SHL_W  = 4 * CW + 4;
  localparam int CMP_W  = SQ_W + 2;

  jstate_t st_r, st_nxt;
  jstep_t  step_r, step_nxt;

  logic signed [DIFF_W-1:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [DIFF_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [DOT_W-1:0]  dot_r, dot_nxt, crs_r, crs_nxt, pterm;
  logic [SQ_W-1:0]          dsq_r, dsq_nxt, csq_r, csq_nxt, sq_term;
  logic [PROD_W-1:0]        p_r, p_nxt;
  logic                     done_r, done_nxt, keep_r, keep_nxt;

  logic [MUL_W-1:0]  ux_m, uy_m, wx_m, wy_m, dh_m, dl_m, ch_m, cl_m, op_a, op_b;
  logic [DOT_W-1:0]  dot_m, crs_m;
  logic [SHL_W-1:0]  p_wide;
  logic [CMP_W-1:0]  dsq_x3;
  logic              neg, degen;

  assign ux_m = ux_r[DIFF_W-1] ? MUL_W'(-ux_r) : MUL_W'(ux_r);
  assign uy_m = uy_r[DIFF_W-1] ? MUL_W'(-uy_r) : MUL_W'(uy_r);
  assign wx_m = wx_r[DIFF_W-1] ? MUL_W'(-wx_r) : MUL_W'(wx_r);
  assign wy_m = wy_r[DIFF_W-1] ? MUL_W'(-wy_r) : MUL_W'(wy_r);

  // Split |dot| and |cross| into a high and a low half for squaring
  assign dot_m = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  assign crs_m = crs_r[DOT_W-1] ? DOT_W'(-crs_r) : DOT_W'(crs_r);
  assign dh_m  = MUL_W'(dot_m[2*CW:CW+1]);
  assign dl_m  = dot_m[CW:0];
  assign ch_m  = MUL_W'(crs_m[2*CW:CW+1]);
  assign cl_m  = crs_m[CW:0];

  assign degen  = ((ux_r == '0) && (uy_r == '0)) || ((wx_r == '0) && (wy_r == '0));
  assign p_wide = SHL_W'(p_r);
  assign pterm  = neg ? -$signed(p_r) : $signed(p_r);
  // |u|^2*|w|^2 = dot^2 + cross^2, so 4*dot^2 < |u|^2*|w|^2 iff 3*dot^2 < cross^2
  assign dsq_x3 = CMP_W'({dsq_r, 1'b0}) + CMP_W'(dsq_r);

  always_comb begin
    op_a    = ux_m;
    op_b    = wx_m;
    neg     = 1'b0;
    sq_term = '0;
    unique case (step_r)
      JS_DOT_X: begin
        op_a = ux_m;
        op_b = wx_m;
        neg  = ux_r[DIFF_W-1] ^ wx_r[DIFF_W-1];
      end
      JS_DOT_Y: begin
        op_a = uy_m;
        op_b = wy_m;
        neg  = uy_r[DIFF_W-1] ^ wy_r[DIFF_W-1];
      end
      JS_CRS_A: begin
        op_a = ux_m;
        op_b = wy_m;
        neg  = ux_r[DIFF_W-1] ^ wy_r[DIFF_W-1];
      end
      JS_CRS_B: begin
        op_a = uy_m;
        op_b = wx_m;
        neg  = !(uy_r[DIFF_W-1] ^ wx_r[DIFF_W-1]);
      end
      JS_DSQ_HH: begin
        op_a    = dh_m;
        op_b    = dh_m;
        sq_term = SQ_W'(p_wide << (2 * CW + 2));
      end
      JS_DSQ_HL: begin
        op_a    = dh_m;
        op_b    = dl_m;
        sq_term = SQ_W'(p_wide << (CW + 2));
      end
      JS_DSQ_LL: begin
        op_a    = dl_m;
        op_b    = dl_m;
        sq_term = SQ_W'(p_r);
      end
      JS_CSQ_HH: begin
        op_a    = ch_m;
        op_b    = ch_m;
        sq_term = SQ_W'(p_wide << (2 * CW + 2));
      end
      JS_CSQ_HL: begin
        op_a    = ch_m;
        op_b    = cl_m;
        sq_term = SQ_W'(p_wide << (CW + 2));
      end
      JS_CSQ_LL: begin
        op_a    = cl_m;
        op_b    = cl_m;
        sq_term = SQ_W'(p_r);
      end
      default: begin
        op_a = ux_m;
        op_b = wx_m;
      end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    ux_nxt   = ux_r;
    uy_nxt   = uy_r;
    wx_nxt   = wx_r;
    wy_nxt   = wy_r;
    dot_nxt  = dot_r;
    crs_nxt  = crs_r;
    dsq_nxt  = dsq_r;
    csq_nxt  = csq_r;
    p_nxt    = p_r;
    done_nxt = 1'b0;
    keep_nxt = keep_r;
    unique case (st_r)
      J_IDLE: begin
        if (start) begin
          ux_nxt   = DIFF_W'(bx) - DIFF_W'(ax);
          uy_nxt   = DIFF_W'(by) - DIFF_W'(ay);
          wx_nxt   = DIFF_W'(cx) - DIFF_W'(bx);
          wy_nxt   = DIFF_W'(cy) - DIFF_W'(by);
          dot_nxt  = '0;
          crs_nxt  = '0;
          dsq_nxt  = '0;
          csq_nxt  = '0;
          step_nxt = JS_DOT_X;
          st_nxt   = J_MUL;
        end
      end
      J_MUL: begin
        priority if (step_r == JS_CMP) begin
          done_nxt = 1'b1;
          keep_nxt = dsq_x3 < CMP_W'(csq_r);
          st_nxt   = J_IDLE;
        end else if ((step_r == JS_CRS_A) && (degen || !dot_r[DOT_W-1])) begin
          // Zero-length edge drops; a right or obtuse corner keeps
          done_nxt = 1'b1;
          keep_nxt = !degen;
          st_nxt   = J_IDLE;
        end else begin
          p_nxt  = PROD_W'(op_a) * PROD_W'(op_b);
          st_nxt = J_ACC;
        end
      end
      J_ACC: begin
        unique case (step_r)
          JS_DOT_X, JS_DOT_Y:               dot_nxt = dot_r + pterm;
          JS_CRS_A, JS_CRS_B:               crs_nxt = crs_r + pterm;
          JS_DSQ_HH, JS_DSQ_HL, JS_DSQ_LL:  dsq_nxt = dsq_r + sq_term;
          JS_CSQ_HH, JS_CSQ_HL, JS_CSQ_LL:  csq_nxt = csq_r + sq_term;
          default: ;
        endcase
        step_nxt = jstep_t'(step_r + 4'd1);
        st_nxt   = J_MUL;
      end
      default: st_nxt = J_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= J_IDLE;
      step_r <= JS_DOT_X;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ux_r   <= ux_nxt;
    uy_r   <= uy_nxt;
    wx_r   <= wx_nxt;
    wy_r   <= wy_nxt;
    dot_r  <= dot_nxt;
    crs_r  <= crs_nxt;
    dsq_r  <= dsq_nxt;
    csq_r  <= csq_nxt;
    p_r    <= p_nxt;
    keep_r <= keep_nxt;
  end

  assign stat = '{done: done_r, keep: keep_r};

endmodule

// ===== rtl/pscf_checker.sv =====
// ----------------------------------------------------------------------------
// Polygon sharp corner filter checker
// Port-level properties of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
`include "polygon_sharp_corner_filter_core_assert.svh"

module pscf_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [15:0]           out_vertex_index,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic                  out_keep,
  input logic                  out_end_of_polygon
);

  // A stalled verdict holds
  `PSCF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_vertex_index) && $stable(out_x) && $stable(out_y) && $stable(out_keep) && $stable(out_end_of_polygon))

  // A vertex in work blocks the next transfer
  `PSCF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // Only vertex 0's verdict closes a polygon, and it always does
  `PSCF_ASSERT_IMP(a_end_is_vertex0, clk, rst_n, out_valid, (out_vertex_index == 16'd0) == out_end_of_polygon)

endmodule

bind polygon_sharp_corner_filter_core pscf_checker #(
  .COORD_BITS (COORD_BITS)
) u_pscf_checker (.*);
